>>> rtl/ccl_pkg.sv
// Shared types and codes for the cursor circular list manager.
// No dependencies; imported by the core and the testbench.
package ccl_pkg;

  localparam int NODES_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int IN_BITS  = 48;
  localparam int OUT_BITS = 48;

  typedef logic [2:0] mode_t;
  typedef logic [2:0] status_t;

  localparam mode_t MD_CREATE   = 3'd0;
  localparam mode_t MD_INSERT   = 3'd1;
  localparam mode_t MD_DELETE   = 3'd2;
  localparam mode_t MD_FIND     = 3'd3;
  localparam mode_t MD_EMPTY    = 3'd4;
  localparam mode_t MD_DEL_LIST = 3'd5;
  localparam mode_t MD_RETRIEVE = 3'd6;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NO_SPACE  = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_NO_POS    = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

endpackage

>>> rtl/ccl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the node value and node link stores.
module ccl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cursor_circular_list_manager_core.sv
// Cursor circular list manager: node store, free list and the list sequencer.
// Depends on ccl_pkg and ccl_ram.
//
// Usage:
//   in_*  : one beat is one operation (create, insert, delete value, find,
//           make empty, delete list, retrieve). in_tready is high only while
//           the sequencer is idle; one operation is in the block at a time.
//   out_* : exactly one result beat per operation, held in an output
//           register, so the next operation is taken while it waits.
// Sequencing: create and retrieve pass the dispatch state, a store-read state and
//   the output state before the result is loaded.
//   Find, delete, insert and make empty walk the ring one node per cycle on
//   the single read port of the link/value stores (delete walks twice). A new
//   operation is taken only after the result of the last one is loaded.
// Reset: rst_n (synchronous, active low) starts a clearing pass over all nodes
//   that chains every node into the free list and zeroes the values;
//   in_tready stays low until it ends.
// Stall: a finished result waits in the output register; the sequencer
//   holds it in its final state until the register frees up.
module cursor_circular_list_manager_core #(
  parameter int NODES      = ccl_pkg::NODES_DEF,
  parameter int VALUE_BITS = ccl_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // mode[2:0], list_head[8:3], position[14:9], value[46:15], zero pad[47]
  input  logic [ccl_pkg::IN_BITS-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status[2:0], result_pos[8:3], result_value[40:9], next_pos[46:41],
  // next_valid[47]
  output logic [ccl_pkg::OUT_BITS-1:0] out_tdata
);

  import ccl_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  localparam int VB = VALUE_BITS;
  localparam logic [LW-1:0] NIL  = LW'(NODES);
  localparam logic [AW:0]   NCNT = (AW+1)'(NODES);

  localparam logic [1:0] WK_PRED = 2'd0;
  localparam logic [1:0] WK_SEEK = 2'd1;
  localparam logic [1:0] WK_RING = 2'd2;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_CR   = 5'd3;
  localparam logic [4:0] S_RT   = 5'd4;
  localparam logic [4:0] S_HEAD = 5'd5;
  localparam logic [4:0] S_WALK = 5'd6;
  localparam logic [4:0] S_IE1  = 5'd7;
  localparam logic [4:0] S_IE2  = 5'd8;
  localparam logic [4:0] S_IF1  = 5'd9;
  localparam logic [4:0] S_IF2  = 5'd10;
  localparam logic [4:0] S_IF3  = 5'd11;
  localparam logic [4:0] S_IF4  = 5'd12;
  localparam logic [4:0] S_IA1  = 5'd13;
  localparam logic [4:0] S_IA2  = 5'd14;
  localparam logic [4:0] S_IA3  = 5'd15;
  localparam logic [4:0] S_IA4  = 5'd16;
  localparam logic [4:0] S_D1   = 5'd17;
  localparam logic [4:0] S_D2   = 5'd18;
  localparam logic [4:0] S_D3   = 5'd19;
  localparam logic [4:0] S_D4   = 5'd20;
  localparam logic [4:0] S_RELC = 5'd21;
  localparam logic [4:0] S_F1   = 5'd22;
  localparam logic [4:0] S_ME1  = 5'd23;
  localparam logic [4:0] S_ME2  = 5'd24;
  localparam logic [4:0] S_ME3  = 5'd25;
  localparam logic [4:0] S_ME4  = 5'd26;
  localparam logic [4:0] S_RELH = 5'd27;
  localparam logic [4:0] S_OUT  = 5'd28;

  logic [4:0]    st_r, st_nxt, ret_r, ret_nxt;
  logic [AW:0]   cnt_r, cnt_nxt, n_r, n_nxt;
  logic [LW-1:0] fh_r, fh_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  mode_t         mode_r, mode_nxt;
  logic          bad_r, bad_nxt, pok_r, pok_nxt;
  logic [AW-1:0] h_r, h_nxt, p_r, p_nxt, t_r, t_nxt;
  logic [VB-1:0] v_r, v_nxt;
  logic [LW-1:0] first_r, first_nxt, cur_r, cur_nxt, tgt_r, tgt_nxt;
  logic [LW-1:0] c_r, c_nxt, pr_r, pr_nxt, nc_r, nc_nxt;
  logic [1:0]    wk_r, wk_nxt;
  logic          found_r, found_nxt;
  status_t       rs_r, rs_nxt;
  logic [5:0]    rp_r, rp_nxt, rn_r, rn_nxt;
  logic [31:0]   rv_r, rv_nxt;
  logic          rnv_r, rnv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0] out_data_r, out_data_nxt;

  // store ports
  logic          lwe, vwe, lram_we;
  logic [AW-1:0] lwa, vwa;
  logic [LW-1:0] lwd, link_q, lnk;
  logic [VB-1:0] vwd, value_q, val;
  logic          lbyp_r, vbyp_r;
  logic [LW-1:0] lbypd_r;
  logic [VB-1:0] vbypd_r;

  logic          space, hit;
  logic [5:0]    hd, ps;

  assign lram_we = lwe && (lwa != '0);

  ccl_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link (
    .clk(clk), .we(lram_we), .waddr(lwa), .wdata(lwd), .raddr(ra_nxt), .rdata(link_q)
  );
  ccl_ram #(.WIDTH(VB), .DEPTH(NODES)) u_value (
    .clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(ra_nxt), .rdata(value_q)
  );

  // node 0 link lives in fh_r; same-cycle write/read goes round the RAM
  assign lnk = (ra_r == '0) ? fh_r : (lbyp_r ? lbypd_r : link_q);
  assign val = vbyp_r ? vbypd_r : value_q;

  assign space = (fh_r != '0) && (fh_r < NIL);
  assign hd = in_tdata[8:3];
  assign ps = in_tdata[14:9];

  always_comb begin
    case (wk_r)
      WK_PRED: hit = (lnk == tgt_r);
      WK_SEEK: hit = (val == v_r);
      WK_RING: hit = (cur_r == {1'b0, p_r});
      default: hit = 1'b0;
    endcase
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cnt_nxt = cnt_r; n_nxt = n_r;
    fh_nxt = fh_r; ra_nxt = ra_r; mode_nxt = mode_r; bad_nxt = bad_r;
    pok_nxt = pok_r; h_nxt = h_r; p_nxt = p_r; t_nxt = t_r; v_nxt = v_r;
    first_nxt = first_r; cur_nxt = cur_r; tgt_nxt = tgt_r; c_nxt = c_r;
    pr_nxt = pr_r; nc_nxt = nc_r; wk_nxt = wk_r; found_nxt = found_r;
    rs_nxt = rs_r; rp_nxt = rp_r; rv_nxt = rv_r; rn_nxt = rn_r; rnv_nxt = rnv_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;
    lwe = 1'b0; lwa = '0; lwd = '0;
    vwe = 1'b0; vwa = '0; vwd = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_CLR: begin
        lwe = 1'b1; lwa = cnt_r[AW-1:0]; lwd = LW'(cnt_r) + LW'(1);
        vwe = 1'b1; vwa = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NCNT - 1'b1) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tdata[2:0];
          bad_nxt  = (hd == '0) || (32'(hd) >= 32'(NODES));
          pok_nxt  = 32'(ps) < 32'(NODES);
          h_nxt    = AW'(hd);
          p_nxt    = AW'(ps);
          v_nxt    = VB'($signed(in_tdata[46:15]));
          st_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        rs_nxt = ST_OK; rp_nxt = '0; rv_nxt = '0; rn_nxt = '0; rnv_nxt = 1'b0;
        st_nxt = S_OUT;
        if (mode_r == MD_CREATE) begin
          if (!space) begin
            rs_nxt = ST_NO_SPACE;
          end else begin
            ra_nxt = fh_r[AW-1:0]; st_nxt = S_CR;
          end
        end else if (mode_r == MD_RETRIEVE) begin
          if (!pok_r) begin
            rs_nxt = ST_NO_POS;
          end else begin
            ra_nxt = p_r; st_nxt = S_RT;
          end
        end else if (bad_r || mode_r > MD_RETRIEVE) begin
          rs_nxt = ST_NO_POS;
        end else if (mode_r == MD_INSERT && !space) begin
          rs_nxt = ST_NO_SPACE;
        end else begin
          ra_nxt = h_r; st_nxt = S_HEAD;
        end
      end
      S_CR: begin
        fh_nxt = lnk;
        lwe = 1'b1; lwa = fh_r[AW-1:0]; lwd = NIL;
        rp_nxt = 6'(fh_r[AW-1:0]);
        st_nxt = S_OUT;
      end
      S_RT: begin
        rv_nxt = 32'($signed(val));
        if (lnk < NIL) begin
          rn_nxt = 6'(lnk[AW-1:0]); rnv_nxt = 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_HEAD: begin
        first_nxt = lnk;
        cur_nxt = lnk; n_nxt = '0; ra_nxt = lnk[AW-1:0]; tgt_nxt = lnk;
        st_nxt = S_OUT;
        case (mode_r)
          MD_INSERT: begin
            if (lnk >= NIL) begin
              if (pok_r && p_r == h_r) begin
                ra_nxt = fh_r[AW-1:0]; st_nxt = S_IE1;
              end else begin
                rs_nxt = ST_NO_POS;
              end
            end else if (pok_r && p_r == h_r) begin
              wk_nxt = WK_PRED; ret_nxt = S_IF1; st_nxt = S_WALK;
            end else if (pok_r) begin
              wk_nxt = WK_RING; ret_nxt = S_IA1; st_nxt = S_WALK;
            end else begin
              rs_nxt = ST_NO_POS;
            end
          end
          MD_DELETE, MD_FIND: begin
            if (lnk >= NIL) begin
              rs_nxt = ST_EMPTY;
            end else begin
              wk_nxt = WK_SEEK; st_nxt = S_WALK;
              ret_nxt = (mode_r == MD_DELETE) ? S_D1 : S_F1;
            end
          end
          default: begin
            if (lnk >= NIL) begin
              st_nxt = (mode_r == MD_DEL_LIST) ? S_RELH : S_OUT;
            end else begin
              st_nxt = S_ME1;
            end
          end
        endcase
      end
      S_WALK: begin
        if (n_r >= NCNT || cur_r >= NIL) begin
          found_nxt = 1'b0; st_nxt = ret_r;
        end else if (hit) begin
          found_nxt = 1'b1; st_nxt = ret_r;
        end else if (lnk == first_r) begin
          found_nxt = 1'b0; st_nxt = ret_r;
        end else begin
          cur_nxt = lnk; ra_nxt = lnk[AW-1:0]; n_nxt = n_r + 1'b1;
        end
      end
      S_IE1: begin
        t_nxt = fh_r[AW-1:0]; fh_nxt = lnk;
        vwe = 1'b1; vwa = fh_r[AW-1:0]; vwd = v_r;
        lwe = 1'b1; lwa = fh_r[AW-1:0]; lwd = fh_r;
        st_nxt = S_IE2;
      end
      S_IE2: begin
        lwe = 1'b1; lwa = h_r; lwd = {1'b0, t_r};
        st_nxt = S_OUT;
      end
      S_IF1: begin
        if (!found_r) begin
          rs_nxt = ST_NO_POS; st_nxt = S_OUT;
        end else begin
          pr_nxt = cur_r; ra_nxt = fh_r[AW-1:0]; st_nxt = S_IF2;
        end
      end
      S_IF2: begin
        t_nxt = fh_r[AW-1:0]; fh_nxt = lnk;
        vwe = 1'b1; vwa = fh_r[AW-1:0]; vwd = v_r;
        lwe = 1'b1; lwa = fh_r[AW-1:0]; lwd = first_r;
        st_nxt = S_IF3;
      end
      S_IF3: begin
        lwe = 1'b1; lwa = pr_r[AW-1:0]; lwd = {1'b0, t_r};
        st_nxt = S_IF4;
      end
      S_IF4: begin
        lwe = 1'b1; lwa = h_r; lwd = {1'b0, t_r};
        st_nxt = S_OUT;
      end
      S_IA1: begin
        if (!found_r) begin
          rs_nxt = ST_NO_POS; st_nxt = S_OUT;
        end else begin
          ra_nxt = fh_r[AW-1:0]; st_nxt = S_IA2;
        end
      end
      S_IA2: begin
        t_nxt = fh_r[AW-1:0]; fh_nxt = lnk;
        vwe = 1'b1; vwa = fh_r[AW-1:0]; vwd = v_r;
        ra_nxt = p_r; st_nxt = S_IA3;
      end
      S_IA3: begin
        lwe = 1'b1; lwa = t_r; lwd = lnk;
        st_nxt = S_IA4;
      end
      S_IA4: begin
        lwe = 1'b1; lwa = p_r; lwd = {1'b0, t_r};
        st_nxt = S_OUT;
      end
      S_D1: begin
        if (!found_r) begin
          rs_nxt = ST_NOT_FOUND; st_nxt = S_OUT;
        end else begin
          c_nxt = cur_r; tgt_nxt = cur_r; wk_nxt = WK_PRED;
          cur_nxt = first_r; n_nxt = '0; ra_nxt = first_r[AW-1:0];
          ret_nxt = S_D2; st_nxt = S_WALK;
        end
      end
      S_D2: begin
        if (!found_r) begin
          rs_nxt = ST_NOT_FOUND; st_nxt = S_OUT;
        end else if (cur_r == c_r) begin
          lwe = 1'b1; lwa = h_r; lwd = NIL;
          st_nxt = S_RELC;
        end else begin
          pr_nxt = cur_r; ra_nxt = c_r[AW-1:0]; st_nxt = S_D3;
        end
      end
      S_D3: begin
        nc_nxt = lnk;
        lwe = 1'b1; lwa = pr_r[AW-1:0]; lwd = lnk;
        st_nxt = S_D4;
      end
      S_D4: begin
        if (c_r == first_r) begin
          lwe = 1'b1; lwa = h_r; lwd = nc_r;
        end
        st_nxt = S_RELC;
      end
      S_RELC: begin
        if (c_r != '0 && c_r < NIL) begin
          lwe = 1'b1; lwa = c_r[AW-1:0]; lwd = fh_r; fh_nxt = c_r;
        end
        st_nxt = S_OUT;
      end
      S_F1: begin
        if (found_r) begin
          rp_nxt = 6'(cur_r[AW-1:0]);
        end else begin
          rs_nxt = ST_NOT_FOUND;
        end
        st_nxt = S_OUT;
      end
      S_ME1: begin
        cur_nxt = lnk; n_nxt = '0; ra_nxt = lnk[AW-1:0]; st_nxt = S_ME2;
      end
      S_ME2: begin
        if (n_r < NCNT && cur_r < NIL && cur_r != first_r) begin
          if (cur_r != '0) begin
            lwe = 1'b1; lwa = cur_r[AW-1:0]; lwd = fh_r; fh_nxt = cur_r;
          end
          cur_nxt = lnk; ra_nxt = lnk[AW-1:0]; n_nxt = n_r + 1'b1;
        end else begin
          st_nxt = S_ME3;
        end
      end
      S_ME3: begin
        if (first_r != '0 && first_r < NIL) begin
          lwe = 1'b1; lwa = first_r[AW-1:0]; lwd = fh_r; fh_nxt = first_r;
        end
        st_nxt = S_ME4;
      end
      S_ME4: begin
        lwe = 1'b1; lwa = h_r; lwd = NIL;
        st_nxt = (mode_r == MD_DEL_LIST) ? S_RELH : S_OUT;
      end
      S_RELH: begin
        lwe = 1'b1; lwa = h_r; lwd = fh_r; fh_nxt = {1'b0, h_r};
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rnv_r, rn_r, rv_r, rp_r, rs_r};
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // link of node 0 is the free-list head register
    if (lwe && lwa == '0) begin
      fh_nxt = lwd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      cnt_r       <= '0;
      fh_r        <= NIL;
      out_valid_r <= 1'b0;
      ra_r        <= '0;
      lbyp_r      <= 1'b0;
      vbyp_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      fh_r        <= fh_nxt;
      out_valid_r <= out_valid_nxt;
      ra_r        <= ra_nxt;
      lbyp_r      <= lram_we && (lwa == ra_nxt);
      vbyp_r      <= vwe && (vwa == ra_nxt);
    end
    lbypd_r <= lwd;     vbypd_r <= vwd;
    ret_r <= ret_nxt;   n_r <= n_nxt;       mode_r <= mode_nxt;
    bad_r <= bad_nxt;   pok_r <= pok_nxt;   h_r <= h_nxt;
    p_r <= p_nxt;       t_r <= t_nxt;       v_r <= v_nxt;
    first_r <= first_nxt; cur_r <= cur_nxt; tgt_r <= tgt_nxt;
    c_r <= c_nxt;       pr_r <= pr_nxt;     nc_r <= nc_nxt;
    wk_r <= wk_nxt;     found_r <= found_nxt;
    rs_r <= rs_nxt;     rp_r <= rp_nxt;     rv_r <= rv_nxt;
    rn_r <= rn_nxt;     rnv_r <= rnv_nxt;   out_data_r <= out_data_nxt;
  end

  a_accept_dispatch : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (st_r == S_DISP))
    else $error("accepted beat not dispatched");

  a_walk_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WALK) |-> (n_r <= NCNT))
    else $error("ring walk ran past node count");

  a_result_load : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && (!out_valid_r || out_tready)) |=> (out_valid_r && in_tready))
    else $error("result not loaded on free output slot");

  a_walk_step : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WALK && $past(st_r) == S_WALK) |-> (n_r == $past(n_r) + 1'b1))
    else $error("walk counter out of step");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for cursor_circular_list_manager_core.
// Depends on ccl_pkg; drives list operations, predicts every result beat and checks it.
module testbench;
  import ccl_pkg::*;

  localparam int      N_NODES    = 64;
  localparam int      NIL        = N_NODES;
  localparam int      IDLE_LIMIT = 3000;
  localparam int      RAND_OPS   = 1800;
  localparam mode_t   MD_UNUSED  = 3'd7;

  // packed from the top bit down: next_valid, next_pos, result_value,
  // result_pos, status
  typedef struct packed {
    logic        nvalid;
    logic [5:0]  npos;
    logic [31:0] rval;
    logic [5:0]  rpos;
    status_t     st;
  } list_result_t;

  typedef struct {
    mode_t       md;
    logic [5:0]  head;
    logic [5:0]  pos;
    logic [31:0] value;
    bit          typed;
    status_t     st;
    logic [5:0]  rpos;
  } list_op_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;

  // model state of the node store
  int          link_mem [N_NODES];
  logic [31:0] value_mem [N_NODES];

  list_result_t pending_results [$];
  int           live_heads [$];
  list_op_t     directed_ops [$];
  int           errors = 0;
  int           beats_out = 0;
  int           idle_cycles = 0;

  always #2 clk = ~clk;

  cursor_circular_list_manager_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic void free_node(int p);
    if (p == 0 || p >= N_NODES) return;
    link_mem[p] = link_mem[0];
    link_mem[0] = p;
  endfunction

  function automatic int node_before(int first, int c);
    int cur;
    int nx;
    cur = first;
    for (int n = 0; n < N_NODES && cur < N_NODES; n++) begin
      nx = link_mem[cur];
      if (nx == c) return cur;
      if (nx == first) return NIL;
      cur = nx;
    end
    return NIL;
  endfunction

  function automatic int seek_node(int first, logic [31:0] v);
    int cur;
    cur = first;
    for (int n = 0; n < N_NODES && cur < N_NODES; n++) begin
      if (value_mem[cur] == v) return cur;
      cur = link_mem[cur];
      if (cur == first) return NIL;
    end
    return NIL;
  endfunction

  function automatic bit on_ring(int first, int p);
    int cur;
    cur = first;
    for (int n = 0; n < N_NODES && cur < N_NODES; n++) begin
      if (cur == p) return 1'b1;
      cur = link_mem[cur];
      if (cur == first) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void clear_list(int h);
    int first;
    int cur;
    int nx;
    first = link_mem[h];
    if (first >= N_NODES) return;
    cur = link_mem[first];
    for (int n = 0; n < N_NODES && cur < N_NODES && cur != first; n++) begin
      nx = link_mem[cur];
      free_node(cur);
      cur = nx;
    end
    free_node(first);
    link_mem[h] = NIL;
  endfunction

  function automatic int grab_free();
    int f;
    f = link_mem[0];
    if (f == 0 || f >= N_NODES) return NIL;
    link_mem[0] = link_mem[f];
    return f;
  endfunction

  function automatic list_result_t apply_list_op(mode_t md, int h, int p, logic [31:0] v);
    list_result_t r;
    bit bad_head;
    bit empty;
    int first;
    int t;
    int c;
    int pr;
    int last;
    r = '0;
    bad_head = (h == 0);
    first = bad_head ? NIL : link_mem[h];
    empty = (first >= N_NODES);
    if (md == MD_CREATE) begin
      t = grab_free();
      if (t == NIL) r.st = ST_NO_SPACE;
      else begin
        link_mem[t] = NIL;
        r.rpos = t[5:0];
      end
    end else if (md == MD_RETRIEVE) begin
      r.rval = value_mem[p];
      if (link_mem[p] < N_NODES) begin
        r.npos = link_mem[p][5:0];
        r.nvalid = 1'b1;
      end
    end else if (md == MD_UNUSED || bad_head) begin
      r.st = ST_NO_POS;
    end else if (md == MD_INSERT) begin
      if (link_mem[0] == 0 || link_mem[0] >= N_NODES) r.st = ST_NO_SPACE;
      else if (empty) begin
        if (p == h) begin
          t = grab_free();
          value_mem[t] = v;
          link_mem[h] = t;
          link_mem[t] = t;
        end else r.st = ST_NO_POS;
      end else if (p == h) begin
        last = node_before(first, first);
        if (last == NIL) r.st = ST_NO_POS;
        else begin
          t = grab_free();
          value_mem[t] = v;
          link_mem[t] = first;
          link_mem[last] = t;
          link_mem[h] = t;
        end
      end else if (on_ring(first, p)) begin
        t = grab_free();
        value_mem[t] = v;
        link_mem[t] = link_mem[p];
        link_mem[p] = t;
      end else r.st = ST_NO_POS;
    end else if (md == MD_DELETE) begin
      if (empty) r.st = ST_EMPTY;
      else begin
        c = seek_node(first, v);
        pr = (c == NIL) ? NIL : node_before(first, c);
        if (pr == NIL) r.st = ST_NOT_FOUND;
        else if (pr == c) begin
          link_mem[h] = NIL;
          free_node(c);
        end else begin
          link_mem[pr] = link_mem[c];
          if (c == first) link_mem[h] = link_mem[c];
          free_node(c);
        end
      end
    end else if (md == MD_FIND) begin
      if (empty) r.st = ST_EMPTY;
      else begin
        c = seek_node(first, v);
        if (c == NIL) r.st = ST_NOT_FOUND;
        else r.rpos = c[5:0];
      end
    end else if (md == MD_EMPTY) begin
      clear_list(h);
    end else begin
      clear_list(h);
      free_node(h);
    end
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one operation beat; the expectation is taken at the accepting edge
  task automatic send_op(list_op_t op, bit no_gaps);
    list_result_t r;
    int gap;
    int idx;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, op.value, op.pos, op.head, op.md};
    do @(posedge clk); while (!in_tready);
    r = apply_list_op(op.md, op.head, op.pos, op.value);
    if (op.typed) begin
      r = '0;
      r.st = op.st;
      r.rpos = op.rpos;
    end
    pending_results.push_back(r);
    if (op.md == MD_CREATE && r.st == ST_OK) live_heads.push_back(r.rpos);
    if (op.md == MD_DEL_LIST) begin
      idx = -1;
      foreach (live_heads[i]) if (live_heads[i] == op.head) idx = i;
      if (idx >= 0) live_heads.delete(idx);
    end
    @(negedge clk);
    gap = no_gaps ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic list_op_t make_op(mode_t md, int h, int p, logic [31:0] v);
    list_op_t op;
    op = '{md, h[5:0], p[5:0], v, 1'b0, ST_OK, 6'd0};
    return op;
  endfunction

  function automatic list_op_t make_checked(mode_t md, int h, int p, logic [31:0] v,
                                            status_t st, int rp);
    list_op_t op;
    op = '{md, h[5:0], p[5:0], v, 1'b1, st, rp[5:0]};
    return op;
  endfunction

  // random ring member of list h, or the header itself when empty
  function automatic int pick_member(int h);
    int ring [$];
    int cur;
    cur = link_mem[h];
    for (int n = 0; n < N_NODES && cur < N_NODES; n++) begin
      ring.push_back(cur);
      cur = link_mem[cur];
      if (cur == link_mem[h]) break;
    end
    if (ring.size() == 0) return h;
    return ring[$urandom_range(0, ring.size() - 1)];
  endfunction

  function automatic list_op_t random_op();
    int h;
    int r;
    int m;
    logic [31:0] v;
    h = (live_heads.size() > 0 && $urandom_range(0, 9) != 0) ?
        live_heads[$urandom_range(0, live_heads.size() - 1)] : $urandom_range(0, 63);
    v = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom;
    r = $urandom_range(0, 99);
    if (r < 12) return make_op(MD_CREATE, $urandom_range(0, 63), $urandom_range(0, 63), v);
    if (r < 45) begin
      m = ($urandom_range(0, 2) == 0) ? h : pick_member(h);
      if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 63);
      return make_op(MD_INSERT, h, m, v);
    end
    if (r < 75) begin
      if ($urandom_range(0, 3) != 0) v = value_mem[pick_member(h)];
      return make_op((r < 60) ? MD_DELETE : MD_FIND, h, $urandom_range(0, 63), v);
    end
    if (r < 80) return make_op(MD_EMPTY, h, $urandom_range(0, 63), v);
    if (r < 85) return make_op(MD_DEL_LIST, h, $urandom_range(0, 63), v);
    if (r < 94) return make_op(MD_RETRIEVE, h, $urandom_range(0, 63), $urandom);
    return make_op(mode_t'($urandom_range(0, 7)), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom);
  endfunction

  // result checker
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      beats_out <= beats_out + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.st != want.st) begin
          $display("%0t: status exp %0d got %0d", $time, want.st, got.st);
          errors++;
        end
        if (got.rpos != want.rpos) begin
          $display("%0t: result_pos exp %0d got %0d", $time, want.rpos, got.rpos);
          errors++;
        end
        if (got.rval != want.rval) begin
          $display("%0t: result_value exp %h got %h", $time, want.rval, got.rval);
          errors++;
        end
        if (got.npos != want.npos) begin
          $display("%0t: next_pos exp %0d got %0d", $time, want.npos, got.npos);
          errors++;
        end
        if (got.nvalid != want.nvalid) begin
          $display("%0t: next_valid exp %0d got %0d", $time, want.nvalid, got.nvalid);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off after 40 beats
  initial begin
    int gap;
    int cnt;
    bit held;
    held = 1'b0;
    cnt = 0;
    @(negedge clk);
    forever begin
      if (!held && beats_out >= 40) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      cnt++;
      gap = ((cnt / 300) % 3 == 2) ? 0 : idle_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    for (int i = 0; i < N_NODES; i++) begin
      link_mem[i] = i + 1;
      value_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_ops.push_back(make_checked(MD_CREATE, 0, 0, 0, ST_OK, 1));
    directed_ops.push_back(make_checked(MD_CREATE, 5, 9, 0, ST_OK, 2));
    directed_ops.push_back(make_checked(MD_FIND, 1, 0, 5, ST_EMPTY, 0));
    directed_ops.push_back(make_checked(MD_INSERT, 1, 1, 32'h7fffffff, ST_OK, 0));
    // front insert onto a one-node ring
    directed_ops.push_back(make_checked(MD_INSERT, 1, 1, 32'h80000000, ST_OK, 0));
    directed_ops.push_back(make_op(MD_INSERT, 1, 3, 32'hffffffff));
    directed_ops.push_back(make_checked(MD_INSERT, 1, 2, 7, ST_NO_POS, 0));
    directed_ops.push_back(make_op(MD_FIND, 1, 0, 32'h80000000));
    directed_ops.push_back(make_checked(MD_FIND, 1, 0, 123, ST_NOT_FOUND, 0));
    directed_ops.push_back(make_op(MD_DELETE, 1, 0, 32'h7fffffff));
    directed_ops.push_back(make_checked(MD_DELETE, 1, 0, 99, ST_NOT_FOUND, 0));
    directed_ops.push_back(make_op(MD_RETRIEVE, 0, 4, 0));
    directed_ops.push_back(make_op(MD_RETRIEVE, 63, 63, 0));
    directed_ops.push_back(make_op(MD_RETRIEVE, 0, 0, 0));
    directed_ops.push_back(make_checked(MD_INSERT, 0, 0, 1, ST_NO_POS, 0));
    directed_ops.push_back(make_checked(MD_UNUSED, 1, 1, 1, ST_NO_POS, 0));
    directed_ops.push_back(make_checked(MD_INSERT, 2, 1, 0, ST_NO_POS, 0));
    directed_ops.push_back(make_checked(MD_INSERT, 2, 2, 0, ST_OK, 0));
    // removing the only node empties the ring
    directed_ops.push_back(make_checked(MD_DELETE, 2, 0, 0, ST_OK, 0));
    directed_ops.push_back(make_checked(MD_EMPTY, 2, 0, 0, ST_OK, 0));
    directed_ops.push_back(make_op(MD_EMPTY, 1, 0, 0));
    directed_ops.push_back(make_op(MD_DEL_LIST, 1, 0, 0));
    directed_ops.push_back(make_op(MD_DEL_LIST, 2, 63, 32'hffffffff));
    foreach (directed_ops[i]) send_op(directed_ops[i], 1'b0);

    for (int i = 0; i < RAND_OPS; i++) send_op(random_op(), ((i / 150) % 4) == 3);
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
